FILE: rtl/humidity_temp_frame_decoder_assert.svh
// Assertion macros used by the frame decoder checker.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define HTFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame decoder check failed");

`endif

FILE: rtl/htfd_pkg.sv
// Package with shared types, constants and the CRC-8 step of the frame decoder.
`default_nettype none

package htfd_pkg;

  localparam int unsigned LAST_POS = 6;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [3:0] ATTEMPT_MAX = 4'hF;
  localparam logic [3:0] RETRY_LIMIT_RESET = 4'd5;

  // Scale factors for hundredths; the products are shifted right by 20.
  localparam logic [13:0] HUM_SCALE = 14'd10000;
  localparam logic [14:0] TEMP_SCALE = 15'd20000;
  localparam logic [14:0] TEMP_OFFSET = 15'd5000;

  typedef enum logic [1:0] {
    RC_OK      = 2'd0,
    RC_RETRY   = 2'd1,
    RC_TIMEOUT = 2'd2,
    RC_CRC_ERR = 2'd3
  } result_code_t;

  typedef struct packed {
    result_code_t code;
    logic [7:0]   status;
    logic [19:0]  hraw;
    logic [19:0]  traw;
  } job_t;

  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/htfd_front.sv
// Front end: accepts bytes, tracks the frame, runs the CRC and classifies each frame.
`default_nettype none

module htfd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic [3:0]    cfg_wr_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_kind,
  input  wire logic [7:0]    in_frame_byte,
  input  wire logic          q_full,
  output logic               q_push,
  output htfd_pkg::job_t     q_push_data
);
  import htfd_pkg::*;

  logic [3:0]  retry_limit_r;
  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [3:0]  attempts_r, attempts_nxt;
  logic [47:0] frame_store_r;
  logic        store_we;
  logic        accept;
  logic [3:0]  attempts_inc;
  logic [7:0]  status;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign status   = frame_store_r[7:0];
  assign attempts_inc = (attempts_r == ATTEMPT_MAX) ? ATTEMPT_MAX : attempts_r + 4'd1;

  always_comb begin
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    attempts_nxt = attempts_r;
    store_we     = 1'b0;
    q_push       = 1'b0;
    q_push_data.code   = RC_OK;
    q_push_data.status = status;
    q_push_data.hraw   = '0;
    q_push_data.traw   = '0;
    if (accept) begin
      if (!in_kind) begin
        pos_nxt      = '0;
        crc_nxt      = CRC_INIT;
        attempts_nxt = '0;
      end else if (pos_r < 3'(LAST_POS)) begin
        store_we = 1'b1;
        crc_nxt  = crc8_fold(crc_r, in_frame_byte);
        pos_nxt  = pos_r + 3'd1;
      end else begin
        q_push  = 1'b1;
        pos_nxt = '0;
        crc_nxt = CRC_INIT;
        if (status[7]) begin
          attempts_nxt     = attempts_inc;
          q_push_data.code = (attempts_inc >= retry_limit_r) ? RC_TIMEOUT : RC_RETRY;
        end else if (crc_r != in_frame_byte) begin
          q_push_data.code = RC_CRC_ERR;
        end else begin
          q_push_data.hraw = {frame_store_r[15:8], frame_store_r[23:16], frame_store_r[31:28]};
          q_push_data.traw = {frame_store_r[27:24], frame_store_r[39:32], frame_store_r[47:40]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= RETRY_LIMIT_RESET;
      pos_r         <= '0;
      crc_r         <= CRC_INIT;
      attempts_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        retry_limit_r <= cfg_wr_data;
      end
      pos_r      <= pos_nxt;
      crc_r      <= crc_nxt;
      attempts_r <= attempts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      frame_store_r[{pos_r, 3'b000} +: 8] <= in_frame_byte;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/htfd_queue.sv
// Two-entry queue of classified frames between the front end and the back end.
`default_nettype none

module htfd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire htfd_pkg::job_t push_data,
  output logic               full,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output htfd_pkg::job_t     pop_data
);
  import htfd_pkg::*;

  job_t       entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_data  = entry_r[rd_ptr_r];
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/htfd_back.sv
// Back end: scales the raw readings in a multiply stage and holds the result register.
`default_nettype none

module htfd_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire htfd_pkg::job_t     q_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_result_code,
  output logic [13:0]             out_humidity_centi,
  output logic signed [14:0]      out_temperature_centi,
  output logic [19:0]             out_hum_reading,
  output logic [19:0]             out_temp_reading,
  output logic [7:0]              out_sensor_status
);
  import htfd_pkg::*;

  logic         s1_valid_r;
  job_t         s1_job_r;
  logic [13:0]  s1_hc_r;
  logic [14:0]  s1_ts_r;
  logic [33:0]  hprod;
  logic [34:0]  tprod;
  logic         s1_adv;
  logic         out_adv;
  logic         out_valid_r;
  logic [1:0]   code_r;
  logic [13:0]  hc_r;
  logic [14:0]  tc_r;
  logic [19:0]  hraw_r;
  logic [19:0]  traw_r;
  logic [7:0]   status_r;
  logic         ok;

  assign out_adv = !out_valid_r || out_ready;
  assign s1_adv  = !s1_valid_r || out_adv;
  assign q_ready = s1_adv;

  assign hprod = 34'(q_data.hraw) * 34'(HUM_SCALE);
  assign tprod = 35'(q_data.traw) * 35'(TEMP_SCALE);
  assign ok    = (s1_job_r.code == RC_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= q_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && q_valid) begin
      s1_job_r <= q_data;
      s1_hc_r  <= hprod[33:20];
      s1_ts_r  <= tprod[34:20];
    end
    if (out_adv && s1_valid_r) begin
      code_r   <= s1_job_r.code;
      status_r <= s1_job_r.status;
      hraw_r   <= s1_job_r.hraw;
      traw_r   <= s1_job_r.traw;
      hc_r     <= ok ? s1_hc_r : '0;
      tc_r     <= ok ? (s1_ts_r - TEMP_OFFSET) : '0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_result_code       = code_r;
  assign out_humidity_centi    = hc_r;
  assign out_temperature_centi = signed'(tc_r);
  assign out_hum_reading       = hraw_r;
  assign out_temp_reading      = traw_r;
  assign out_sensor_status     = status_r;

endmodule

`default_nettype wire

FILE: rtl/humidity_temp_frame_decoder.sv
// A frame's result passes through the queue entry, the multiply stage and the output register.
// Throughput: one input transfer per cycle; the front end stalls only when its queue is full.
// Bytes that do not end a frame and start markers give no result; they wait only while the queue is full.
// The CRC-8 step is unrolled, so each byte is folded in the cycle it arrives.
// Reset (synchronous, active low) clears position, busy count, queue and valid flags;
// the CRC returns to its initial value and the retry limit to five.
`default_nettype none

module humidity_temp_frame_decoder (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic [3:0]    cfg_wr_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_kind,
  input  wire logic [7:0]    in_frame_byte,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         out_result_code,
  output logic [13:0]        out_humidity_centi,
  output logic signed [14:0] out_temperature_centi,
  output logic [19:0]        out_hum_reading,
  output logic [19:0]        out_temp_reading,
  output logic [7:0]         out_sensor_status
);
  import htfd_pkg::*;

  // The front end owns all frame state. It classifies a completed frame
  // (busy retry, busy timeout, CRC error or good) and hands the result
  // to the queue as a single job.
  logic q_push;
  job_t q_push_data;
  logic q_full;
  logic q_valid;
  logic q_ready;
  job_t q_data;

  htfd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_frame_byte (in_frame_byte),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_push_data   (q_push_data)
  );

  // The queue decouples input ready from the output handshake: in_ready
  // depends only on the registered fill count.
  htfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data)
  );

  // The back end multiplies the raw readings by the scale factors in one
  // registered stage, then subtracts the temperature offset and zeroes the
  // scaled humidity and temperature of non-good results as it loads the output register.
  htfd_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .q_ready               (q_ready),
    .q_data                (q_data),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_result_code       (out_result_code),
    .out_humidity_centi    (out_humidity_centi),
    .out_temperature_centi (out_temperature_centi),
    .out_hum_reading       (out_hum_reading),
    .out_temp_reading      (out_temp_reading),
    .out_sensor_status     (out_sensor_status)
  );

endmodule

`default_nettype wire

FILE: rtl/htfd_checker.sv
// Port-level checker for the frame decoder and the bind that attaches it.
`default_nettype none
`include "humidity_temp_frame_decoder_assert.svh"

module htfd_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         out_result_code,
  input wire logic [13:0]        out_humidity_centi,
  input wire logic signed [14:0] out_temperature_centi,
  input wire logic [19:0]        out_hum_reading,
  input wire logic [19:0]        out_temp_reading,
  input wire logic [7:0]         out_sensor_status
);
  import htfd_pkg::*;

  `HTFD_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid)
  `HTFD_ASSERT_SAME(a_fail_zeroed, clk, rst_n, out_valid && out_result_code != RC_OK, out_hum_reading == 20'd0 && out_temp_reading == 20'd0 && out_humidity_centi == 14'd0 && out_temperature_centi == 15'sd0)
  `HTFD_ASSERT_SAME(a_hum_range, clk, rst_n, out_valid && out_result_code == RC_OK, out_humidity_centi <= 14'd9999)
  `HTFD_ASSERT_SAME(a_busy_status, clk, rst_n, out_valid && (out_result_code == RC_RETRY || out_result_code == RC_TIMEOUT), out_sensor_status[7])

endmodule

bind humidity_temp_frame_decoder htfd_checker u_checker (.*);

`default_nettype wire

FILE: dv/humidity_temp_frame_decoder_tb.sv
// Self-checking testbench for the humidity and temperature frame decoder.
`timescale 1ns / 100ps

package htfd_tb_pkg;
  import htfd_pkg::*;

  localparam int BUSY_BIT = 7;
  localparam int REPORT_CAP = 200;

  typedef struct packed {
    result_code_t       code;
    logic [13:0]        hum_centi;
    logic signed [14:0] temp_centi;
    logic [19:0]        hum_raw;
    logic [19:0]        temp_raw;
    logic [7:0]         status;
  } frame_result_t;

  // CRC-8 over one byte, processed one bit at a time from the MSB.
  function automatic logic [7:0] crc_step(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  class frame_scoreboard;
    logic [3:0]    retry_limit;
    logic [2:0]    byte_pos;
    logic [7:0]    running_crc;
    logic [7:0]    frame_bytes [6];
    logic [3:0]    busy_count;
    frame_result_t pending_results [$];
    int unsigned   mismatches;

    function new();
      retry_limit = RETRY_LIMIT_RESET;
      byte_pos    = '0;
      running_crc = CRC_INIT;
      busy_count  = '0;
      mismatches  = 0;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
    endfunction

    function void set_retry_limit(input logic [3:0] v);
      retry_limit = v;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Advances the decoder state by one accepted input and queues any result.
    function void note_input(input bit is_byte, input logic [7:0] b);
      frame_result_t     r;
      logic [19:0]       h;
      logic [19:0]       t;
      longint unsigned   hp;
      longint unsigned   tp;
      if (!is_byte) begin
        busy_count  = '0;
        byte_pos    = '0;
        running_crc = CRC_INIT;
        return;
      end
      if (byte_pos < LAST_POS) begin
        frame_bytes[byte_pos] = b;
        running_crc = crc_step(running_crc, b);
        byte_pos++;
        return;
      end
      r = '0;
      r.code = RC_OK;
      r.status = frame_bytes[0];
      if (frame_bytes[0][BUSY_BIT]) begin
        if (busy_count != ATTEMPT_MAX) busy_count++;
        r.code = (busy_count >= retry_limit) ? RC_TIMEOUT : RC_RETRY;
      end else if (running_crc != b) begin
        r.code = RC_CRC_ERR;
      end else begin
        h  = {frame_bytes[1], frame_bytes[2], frame_bytes[3][7:4]};
        t  = {frame_bytes[3][3:0], frame_bytes[4], frame_bytes[5]};
        hp = (64'(h) * 64'(HUM_SCALE)) >> 20;
        tp = ((64'(t) * 64'(TEMP_SCALE)) >> 20) - 64'(TEMP_OFFSET);
        r.hum_raw    = h;
        r.temp_raw   = t;
        r.hum_centi  = hp[13:0];
        r.temp_centi = tp[14:0];
      end
      byte_pos    = '0;
      running_crc = CRC_INIT;
      pending_results.push_back(r);
    endfunction

    task report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task check_result(input frame_result_t got);
      frame_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result (status byte)", got.status, -1);
        return;
      end
      want = pending_results.pop_front();
      if (got.code !== want.code)
        report_mismatch("result_code", got.code, want.code);
      if (got.hum_centi !== want.hum_centi)
        report_mismatch("humidity_centi", got.hum_centi, want.hum_centi);
      if (got.temp_centi !== want.temp_centi)
        report_mismatch("temperature_centi", got.temp_centi, want.temp_centi);
      if (got.hum_raw !== want.hum_raw)
        report_mismatch("humidity reading", got.hum_raw, want.hum_raw);
      if (got.temp_raw !== want.temp_raw)
        report_mismatch("temperature reading", got.temp_raw, want.temp_raw);
      if (got.status !== want.status)
        report_mismatch("sensor_status", got.status, want.status);
    endtask
  endclass

endpackage

module humidity_temp_frame_decoder_tb;
  import htfd_pkg::*;
  import htfd_tb_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS  = 120;
  localparam int NUM_PHASES   = 8;
  localparam bit KIND_START   = 1'b0;
  localparam bit KIND_BYTE    = 1'b1;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [7:0]  in_frame_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_result_code;
  logic [13:0] out_humidity_centi;
  logic signed [14:0] out_temperature_centi;
  logic [19:0] out_hum_reading;
  logic [19:0] out_temp_reading;
  logic [7:0]  out_sensor_status;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  // The main thread bumps this to ask the receiver for one long hold-off.
  int unsigned hold_requests;
  int unsigned items_sent;
  int unsigned cycle_count;

  frame_scoreboard sb;

  humidity_temp_frame_decoder dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_kind               (in_kind),
    .in_frame_byte         (in_frame_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_result_code       (out_result_code),
    .out_humidity_centi    (out_humidity_centi),
    .out_temperature_centi (out_temperature_centi),
    .out_hum_reading       (out_hum_reading),
    .out_temp_reading      (out_temp_reading),
    .out_sensor_status     (out_sensor_status)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver. The ready line moves only at the falling edge. When a hold-off is
  // requested, ready stays low until the hold-off counter here runs out, so the
  // decoder's result queue fills and it must push back on its input.
  initial begin
    int unsigned hold_left;
    int unsigned hold_served;
    hold_left   = 0;
    hold_served = 0;
    out_ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Result monitor. Outputs are sampled at the rising edge, before the
  // decoder's own updates for that edge take effect.
  always @(posedge clk) begin
    frame_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.code       = result_code_t'(out_result_code);
      got.hum_centi  = out_humidity_centi;
      got.temp_centi = out_temperature_centi;
      got.hum_raw    = out_hum_reading;
      got.temp_raw   = out_temp_reading;
      got.status     = out_sensor_status;
      sb.check_result(got);
    end
  end

  // Offers one item and returns at the falling edge after its transfer. Valid
  // stays high into the next item unless a random idle gap is drawn.
  task automatic send_item(input bit kind, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_kind       = kind;
    in_frame_byte = b;
    do @(posedge clk); while (!in_ready);
    sb.note_input(kind, b);
    items_sent++;
    @(negedge clk);
  endtask

  // A start marker carries a random byte that the decoder must ignore.
  task automatic send_marker();
    send_item(KIND_START, 8'($urandom));
  endtask

  // Sends a status byte, five data bytes and the CRC, optionally corrupted.
  task automatic send_frame(input logic [7:0] status, input logic [39:0] data, input bit corrupt);
    logic [7:0] crc;
    logic [7:0] b;
    crc = crc_step(CRC_INIT, status);
    send_item(KIND_BYTE, status);
    for (int i = 4; i >= 0; i--) begin
      b   = data[i*8 +: 8];
      crc = crc_step(crc, b);
      send_item(KIND_BYTE, b);
    end
    if (corrupt) crc = crc ^ 8'($urandom_range(1, 255));
    send_item(KIND_BYTE, crc);
  endtask

  // Frames from a busy sensor, enough of them to pass the retry limit. With a
  // long enough run the attempt count also saturates.
  task automatic send_busy_run(input int unsigned frames);
    send_marker();
    repeat (frames)
      send_frame(8'($urandom_range(8'h80, 8'hFF)), {$urandom, 8'($urandom)},
                 $urandom_range(0, 1));
  endtask

  // Mostly well-formed frames with random content; the rest are markers,
  // frames cut short, stray bytes and bad CRCs.
  task automatic send_random_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0]  status;
    logic [39:0] data;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_marker();
      end else if (pick < 13) begin
        // A partial frame, then a marker to drop it.
        repeat ($urandom_range(1, 6)) send_item(KIND_BYTE, 8'($urandom));
        send_marker();
      end else if (pick < 15) begin
        // Stray bytes shift the frame boundary; both sides follow the shift.
        send_item(KIND_BYTE, 8'($urandom));
      end
      status = ($urandom_range(0, 99) < 30) ? 8'($urandom_range(8'h80, 8'hFF))
                                            : 8'($urandom_range(8'h00, 8'h7F));
      case ($urandom_range(0, 19))
        0: data = '0;
        1: data = '1;
        default: data = {$urandom, 8'($urandom)};
      endcase
      send_frame(status, data, $urandom_range(0, 99) < 15);
    end
  endtask

  // Waits until every expected result has arrived, then lets the last
  // result-free items drain through the pipeline.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_retry_limit(input logic [3:0] v);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    sb.set_retry_limit(v);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin
    logic [3:0]  limit_val;
    int unsigned burst;
    sb             = new();
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_kind        = 1'b0;
    in_frame_byte  = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests  = 0;
    items_sent     = 0;
    cycle_count    = 0;

    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part, with the retry limit still at its reset value.
    send_marker();
    // All-zero data with a good CRC: the lowest humidity and temperature.
    send_frame(8'h00, 40'h00_0000_0000, 1'b0);
    // All-ones data straight after, with no marker between the frames.
    send_frame(8'h7F, 40'hFF_FFFF_FFFF, 1'b0);
    send_marker();
    // A busy status is reported even though the CRC is wrong.
    send_frame(8'hFF, 40'hA5_5A_C3_3C_96, 1'b1);
    // A marker in the middle of a frame drops the partial frame.
    send_item(KIND_BYTE, 8'h80);
    send_item(KIND_BYTE, 8'h12);
    send_marker();

    // Each phase pairs an idling mode with a retry limit. The first keeps the
    // reset limit; the others cover zero, both ends of the range and random
    // values.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase)
        0: limit_val = RETRY_LIMIT_RESET;
        1: limit_val = 4'd0;
        2: limit_val = 4'd15;
        3: limit_val = 4'd1;
        6: limit_val = 4'd15;
        default: limit_val = 4'($urandom_range(1, 15));
      endcase
      if (phase != 0) write_retry_limit(limit_val);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      // Back pressure: the receiver stops for a long stretch while the
      // sender keeps offering at full rate.
      if (phase == 4) hold_requests++;
      burst = (limit_val > 4'd15 - 2) ? 17 : limit_val + 2;
      send_busy_run(burst);
      send_random_traffic(PHASE_ITEMS);
    end

    drain();
    if (sb.pending() != 0)
      sb.report_mismatch("results still expected", 0, sb.pending());
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
